### design/wpj_pkg.sv
// shared types, constants and arithmetic helpers for the warped pixel jacobian
package wpj_pkg;

  localparam int DataWidth = 32;
  localparam int DefFracBits = 16;
  localparam int NumRegs = 6;
  localparam int RegIdxWidth = 3;
  localparam int QuoWidth = 34;

  typedef enum logic [RegIdxWidth-1:0] {
    REG_R0C0 = 3'd0,
    REG_R0C1 = 3'd1,
    REG_R1C0 = 3'd2,
    REG_R1C1 = 3'd3,
    REG_R2C0 = 3'd4,
    REG_R2C1 = 3'd5
  } reg_idx_t;

  typedef logic signed [DataWidth-1:0] word_t;

  typedef struct packed {
    word_t r0c0;
    word_t r0c1;
    word_t r1c0;
    word_t r1c1;
    word_t r2c0;
    word_t r2c1;
  } warp_t;

  typedef struct packed {
    word_t tmpl_x;
    word_t tmpl_y;
    word_t warped_x;
    word_t warped_y;
    word_t denom;
    word_t grad_x;
    word_t grad_y;
  } pix_in_t;

  typedef struct packed {
    word_t deriv_0;
    word_t deriv_1;
    word_t deriv_2;
    word_t deriv_3;
    word_t deriv_4;
    word_t deriv_5;
    word_t deriv_6;
    word_t deriv_7;
    logic  zero_denom;
  } pix_out_t;

  // clamp a wide signed value to 32 bits
  function automatic word_t sat32(input logic signed [69:0] v);
    word_t r;
    if (v > 70'sd2147483647) r = 32'sh7fffffff;
    else if (v < -70'sd2147483648) r = 32'sh80000000;
    else r = v[DataWidth-1:0];
    return r;
  endfunction

endpackage

### design/wpj_if.sv
// valid/ready channel carrying one payload
interface wpj_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### design/wpj_mul.sv
// registered rounding fixed-point multiplier with saturation
module wpj_mul import wpj_pkg::*; #(
  parameter int FRAC_BITS = DefFracBits
) (
  input  logic  clk,
  input  logic  en,
  input  word_t a,
  input  word_t b,
  output word_t p
);
  logic signed [63:0] prod;
  logic signed [69:0] rnd;

  always_comb begin
    prod = a * b;
    rnd = (70'(prod) + (70'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p <= sat32(rnd);
    end
  end
endmodule

### design/wpj_div.sv
// pipelined restoring divider, one quotient bit per stage, rounded and saturated
module wpj_div import wpj_pkg::*; #(
  parameter int FRAC_BITS = DefFracBits,
  parameter int Stages = QuoWidth
) (
  input  logic  clk,
  input  logic  en,
  input  word_t num,
  input  word_t den,
  output word_t quo
);
  localparam int NW = DataWidth + FRAC_BITS + 1;

  // numerator is scaled by 2^FRAC_BITS and offset by half the divisor up front
  logic [NW-1:0]   rem [Stages+1];
  logic [NW-1:0]   dvd [Stages+1];
  logic [DataWidth:0] dv [Stages+1];
  logic [Stages-1:0] q [Stages+1];
  logic            neg [Stages+1];
  logic [DataWidth:0] un_abs;
  logic [DataWidth:0] ud_abs;

  always_comb begin
    un_abs = num[DataWidth-1] ? (DataWidth+1)'(-33'(num)) : (DataWidth+1)'(num);
    ud_abs = den[DataWidth-1] ? (DataWidth+1)'(-33'(den)) : (DataWidth+1)'(den);
    rem[0] = '0;
    dvd[0] = (NW'(un_abs) << FRAC_BITS) + NW'(ud_abs >> 1);
    dv[0]  = ud_abs;
    q[0]   = '0;
    neg[0] = num[DataWidth-1] ^ den[DataWidth-1];
  end

  for (genvar s = 0; s < Stages; s++) begin : g_stage
    logic [NW:0] trial;
    logic [NW-1:0] dvd_sh;
    logic bitv;
    always_comb begin
      // the first stage picks up the remaining high dividend bits
      if (s == 0) begin
        trial = {1'b0, dvd[s] >> (Stages - 1)};
        dvd_sh = dvd[s] & ((NW'(1) << (Stages - 1)) - NW'(1));
      end else begin
        trial = {rem[s], dvd[s][Stages-1-s]};
        dvd_sh = dvd[s];
      end
      bitv = trial >= (NW+1)'(dv[s]);
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem[s+1] <= bitv ? NW'(trial - (NW+1)'(dv[s])) : NW'(trial);
        dvd[s+1] <= dvd_sh;
        dv[s+1]  <= dv[s];
        q[s+1]   <= {q[s][Stages-2:0], bitv};
        neg[s+1] <= neg[s];
      end
    end
  end

  logic [Stages-1:0] qc;
  always_comb begin
    qc = (q[Stages] > Stages'(33'h80000000)) ? Stages'(33'h80000000) : q[Stages];
    quo = sat32(neg[Stages] ? -70'(qc) : 70'(qc));
  end
endmodule

### design/warped_pixel_jacobian_unit.sv
// top level: warp jacobian, gradient back-mapping, division and sl3 derivatives
// register stages: 4 + 34 + 1 + 2 + 1 = 42 from the input to the output register
// throughput: one transaction per cycle while the output is not stalled; the divider is a 34-stage bit pipeline
// a stall freezes the whole pipeline; the output register holds the result
// reset clears the valid bits and loads the identity warp
module warped_pixel_jacobian_unit import wpj_pkg::*; #(
  parameter int FRAC_BITS = DefFracBits
) (
  input  logic                  clk,
  input  logic                  rst,
  wpj_if.sink                   pix_in,
  wpj_if.source                 pix_out,
  input  logic                  cfg_we,
  input  logic [RegIdxWidth-1:0] cfg_idx,
  input  word_t                 cfg_data
);
  localparam int Lat = 7 + QuoWidth;

  warp_t warp;
  always_ff @(posedge clk) begin
    if (rst) begin
      warp <= '{r0c0: 32'sd1 <<< FRAC_BITS, r1c1: 32'sd1 <<< FRAC_BITS, default: '0};
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_R0C0: warp.r0c0 <= cfg_data;
        REG_R0C1: warp.r0c1 <= cfg_data;
        REG_R1C0: warp.r1c0 <= cfg_data;
        REG_R1C1: warp.r1c1 <= cfg_data;
        REG_R2C0: warp.r2c0 <= cfg_data;
        REG_R2C1: warp.r2c1 <= cfg_data;
        default: ;
      endcase
    end
  end

  logic en;
  logic [Lat-1:0] vld;
  assign en = !pix_out.valid || pix_out.ready;
  assign pix_in.ready = en;

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[Lat-2:0], pix_in.valid};
  end

  // side data delayed along the pipe
  pix_in_t side [Lat];
  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= pix_in.data;
      for (int i = 1; i < Lat; i++) side[i] <= side[i-1];
    end
  end

  // stage a: products of the r2 row with the warped point
  word_t m_xx, m_xy, m_yx, m_yy;
  wpj_mul #(.FRAC_BITS(FRAC_BITS)) u_m0 (.clk, .en, .a(warp.r2c0), .b(pix_in.data.warped_x), .p(m_xx));
  wpj_mul #(.FRAC_BITS(FRAC_BITS)) u_m1 (.clk, .en, .a(warp.r2c1), .b(pix_in.data.warped_x), .p(m_xy));
  wpj_mul #(.FRAC_BITS(FRAC_BITS)) u_m2 (.clk, .en, .a(warp.r2c0), .b(pix_in.data.warped_y), .p(m_yx));
  wpj_mul #(.FRAC_BITS(FRAC_BITS)) u_m3 (.clk, .en, .a(warp.r2c1), .b(pix_in.data.warped_y), .p(m_yy));

  // stage b: jacobian entries
  word_t jxx, jxy, jyx, jyy;
  always_ff @(posedge clk) begin
    if (en) begin
      jxx <= sat32(70'(warp.r0c0) - 70'(m_xx));
      jxy <= sat32(70'(warp.r0c1) - 70'(m_xy));
      jyx <= sat32(70'(warp.r1c0) - 70'(m_yx));
      jyy <= sat32(70'(warp.r1c1) - 70'(m_yy));
    end
  end

  // stage c: gradient products
  word_t p0, p1, p2, p3;
  wpj_mul #(.FRAC_BITS(FRAC_BITS)) u_m4 (.clk, .en, .a(jxx), .b(side[1].grad_x), .p(p0));
  wpj_mul #(.FRAC_BITS(FRAC_BITS)) u_m5 (.clk, .en, .a(jyx), .b(side[1].grad_y), .p(p1));
  wpj_mul #(.FRAC_BITS(FRAC_BITS)) u_m6 (.clk, .en, .a(jxy), .b(side[1].grad_x), .p(p2));
  wpj_mul #(.FRAC_BITS(FRAC_BITS)) u_m7 (.clk, .en, .a(jyy), .b(side[1].grad_y), .p(p3));

  // stage d: numerators
  word_t nx, ny;
  always_ff @(posedge clk) begin
    if (en) begin
      nx <= sat32(70'(p0) + 70'(p1));
      ny <= sat32(70'(p2) + 70'(p3));
    end
  end

  // divider stages
  word_t ix, iy;
  wpj_div #(.FRAC_BITS(FRAC_BITS)) u_dx (.clk, .en, .num(nx), .den(side[3].denom), .quo(ix));
  wpj_div #(.FRAC_BITS(FRAC_BITS)) u_dy (.clk, .en, .num(ny), .den(side[3].denom), .quo(iy));

  localparam int SQ = 4 + QuoWidth;
  word_t ixr, iyr;
  always_ff @(posedge clk) begin
    if (en) begin
      ixr <= ix;
      iyr <= iy;
    end
  end

  // first-order terms
  word_t ixx, ixy, iyy, iyx, ix2, iy2;
  wpj_mul #(.FRAC_BITS(FRAC_BITS)) u_m8  (.clk, .en, .a(ixr), .b(side[SQ].tmpl_x), .p(ixx));
  wpj_mul #(.FRAC_BITS(FRAC_BITS)) u_m9  (.clk, .en, .a(ixr), .b(side[SQ].tmpl_y), .p(ixy));
  wpj_mul #(.FRAC_BITS(FRAC_BITS)) u_m10 (.clk, .en, .a(iyr), .b(side[SQ].tmpl_y), .p(iyy));
  wpj_mul #(.FRAC_BITS(FRAC_BITS)) u_m11 (.clk, .en, .a(iyr), .b(side[SQ].tmpl_x), .p(iyx));
  always_ff @(posedge clk) begin
    if (en) begin
      ix2 <= ixr;
      iy2 <= iyr;
    end
  end

  // second-order terms
  word_t a0, a1, b0, b1, ix3, iy3, ixx3, ixy3, iyy3, iyx3;
  wpj_mul #(.FRAC_BITS(FRAC_BITS)) u_m12 (.clk, .en, .a(ixx), .b(side[SQ+1].tmpl_x), .p(a0));
  wpj_mul #(.FRAC_BITS(FRAC_BITS)) u_m13 (.clk, .en, .a(iyy), .b(side[SQ+1].tmpl_x), .p(a1));
  wpj_mul #(.FRAC_BITS(FRAC_BITS)) u_m14 (.clk, .en, .a(ixx), .b(side[SQ+1].tmpl_y), .p(b0));
  wpj_mul #(.FRAC_BITS(FRAC_BITS)) u_m15 (.clk, .en, .a(iyy), .b(side[SQ+1].tmpl_y), .p(b1));
  always_ff @(posedge clk) begin
    if (en) begin
      ix3 <= ix2; iy3 <= iy2;
      ixx3 <= ixx; ixy3 <= ixy; iyy3 <= iyy; iyx3 <= iyx;
    end
  end

  // output register
  pix_out_t res;
  logic zd;
  assign zd = side[Lat-1].denom == '0;
  always_ff @(posedge clk) begin
    if (en) begin
      res.zero_denom <= zd;
      res.deriv_0 <= zd ? '0 : sat32(70'(ixx3) - 70'(iyx3));
      res.deriv_1 <= zd ? '0 : sat32(-(70'(iyy3) * 70'sd2 + 70'(ixx3)));
      res.deriv_2 <= zd ? '0 : sat32(70'(iyx3) - 70'(ixy3));
      res.deriv_3 <= zd ? '0 : sat32(70'(iyx3) + 70'(ixy3));
      res.deriv_4 <= zd ? '0 : ix3;
      res.deriv_5 <= zd ? '0 : iy3;
      res.deriv_6 <= zd ? '0 : sat32(-(70'(a0) + 70'(a1)));
      res.deriv_7 <= zd ? '0 : sat32(-(70'(b0) + 70'(b1)));
    end
  end

  logic ovld;
  always_ff @(posedge clk) begin
    if (rst) ovld <= 1'b0;
    else if (en) ovld <= vld[Lat-1];
  end
  assign pix_out.valid = ovld;
  assign pix_out.data = res;

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld)) else $error("valid bits moved during stall");
  a_zero_flag: assert property (@(posedge clk) disable iff (rst)
    pix_out.valid && pix_out.data.zero_denom |-> pix_out.data.deriv_4 == '0)
    else $error("zero denominator result not cleared");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !pix_out.valid |-> pix_in.ready) else $error("input blocked with empty output");
endmodule
